// ----- rtl/bpbd_pkg.sv -----
// Shared constants and types for the bright-pass box downsampler.
`default_nettype none

package bpbd_pkg;

    localparam int PIX_W      = 8;
    localparam int SUM_W      = PIX_W + 1;
    localparam int QUAD_W     = PIX_W + 2;
    localparam int LINE_DW    = 3 * SUM_W;
    localparam int LUMA_W     = 22;
    localparam int LW_W       = 13;
    localparam int CFG_DW     = 22;
    localparam int CFG_IDX_W  = 2;

    localparam int DEFAULT_MAX_WIDTH = 4096;

    // Luminance weights scaled by 10000
    localparam logic [LUMA_W-1:0] LUMA_WEIGHT_R = LUMA_W'(2125);
    localparam logic [LUMA_W-1:0] LUMA_WEIGHT_G = LUMA_W'(7154);
    localparam logic [LUMA_W-1:0] LUMA_WEIGHT_B = LUMA_W'(721);

    localparam logic [LW_W-1:0]   LINE_WIDTH_RST   = LW_W'(1920);
    localparam logic              BP_ENABLE_RST    = 1'b1;
    localparam logic [LUMA_W-1:0] LUMA_THRESH_RST  = LUMA_W'(2040000);

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_LINE_WIDTH     = 2'd0,
        REG_BP_ENABLE      = 2'd1,
        REG_LUMA_THRESHOLD = 2'd2
    } cfg_reg_t;

endpackage

`default_nettype wire

// ----- rtl/bpbd_line_store.sv -----
// Line store of even-row column-pair sums: one write and one registered read per cycle.
`default_nettype none

module bpbd_line_store
    import bpbd_pkg::*;
#(
    parameter int DEPTH  = DEFAULT_MAX_WIDTH / 2,
    parameter int ADDR_W = $clog2(DEFAULT_MAX_WIDTH / 2)
)
(
    input  wire                 clk,
    input  wire                 wr_en,
    input  wire  [ADDR_W-1:0]   wr_addr,
    input  wire  [LINE_DW-1:0]  wr_data,
    input  wire                 rd_en,
    input  wire  [ADDR_W-1:0]   rd_addr,
    output logic [LINE_DW-1:0]  rd_data
);

    logic [LINE_DW-1:0] line_mem [DEPTH];
    logic [LINE_DW-1:0] rd_data_reg;

    // Read data holds until the next read, so a stalled consumer keeps it
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            line_mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= line_mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

// ----- rtl/bright_pass_box_downsample.sv -----
// Top level: bright-pass filter and 2x2 box downsample of a raster RGB stream.
// Path: the transaction that completes a 2x2 block passes luma, filter/line access,
//   final sum and output register. Each pixel makes at most one line store access.
// Throughput: one pixel per cycle, while the output is not stalled by out_ready.
// Reset: position, pipeline valids and configuration return to defaults; the line
//   store is not cleared, as every entry is written on the even row before it is read.
`default_nettype none

module bright_pass_box_downsample
    import bpbd_pkg::*;
#(
    parameter int MAX_WIDTH = DEFAULT_MAX_WIDTH
)
(
    input  wire                   clk,
    input  wire                   rst_n,

    input  wire                   cfg_we,
    input  wire  [CFG_IDX_W-1:0]  cfg_index,
    input  wire  [CFG_DW-1:0]     cfg_data,

    input  wire                   in_valid,
    output logic                  in_ready,
    input  wire                   start_of_frame,
    input  wire  [PIX_W-1:0]      red,
    input  wire  [PIX_W-1:0]      green,
    input  wire  [PIX_W-1:0]      blue,

    output logic                  out_valid,
    input  wire                   out_ready,
    output logic [PIX_W-1:0]      avg_red,
    output logic [PIX_W-1:0]      avg_green,
    output logic [PIX_W-1:0]      avg_blue,
    output logic                  row_end
);

    localparam int LINE_DEPTH = MAX_WIDTH / 2;
    localparam int ADDR_W     = $clog2(LINE_DEPTH);
    localparam int CW         = $clog2(MAX_WIDTH);
    localparam int WW         = $clog2(MAX_WIDTH + 1);
    localparam int EW         = (WW > LW_W) ? WW : LW_W;

    // ---------------- configuration ----------------
    logic [LW_W-1:0]   line_width_reg;
    logic              bp_enable_reg;
    logic [LUMA_W-1:0] luma_thresh_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            line_width_reg  <= LINE_WIDTH_RST;
            bp_enable_reg   <= BP_ENABLE_RST;
            luma_thresh_reg <= LUMA_THRESH_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_LINE_WIDTH:     line_width_reg  <= cfg_data[LW_W-1:0];
                REG_BP_ENABLE:      bp_enable_reg   <= cfg_data[0];
                REG_LUMA_THRESHOLD: luma_thresh_reg <= cfg_data[LUMA_W-1:0];
                default:            ;
            endcase
        end
    end

    // Clamp width to [2, MAX_WIDTH]
    logic [EW-1:0] lw_ext;
    logic [EW-1:0] width_clamped;
    logic [WW-1:0] width_eff;
    logic [WW-1:0] width_even;

    assign lw_ext = EW'(line_width_reg);

    always_comb
    begin
        if (lw_ext < EW'(2))
        begin
            width_clamped = EW'(2);
        end
        else if (lw_ext > EW'(MAX_WIDTH))
        begin
            width_clamped = EW'(MAX_WIDTH);
        end
        else
        begin
            width_clamped = lw_ext;
        end
    end

    assign width_eff  = width_clamped[WW-1:0];
    assign width_even = {width_eff[WW-1:1], 1'b0};

    // ---------------- pipeline handshake ----------------
    logic s1_valid_reg, s2_valid_reg, s3_valid_reg, out_valid_reg;
    logic out_load, s3_load, s2_load, s1_load;
    logic s2_result, s2_fire, in_fire;

    assign out_load = !out_valid_reg || out_ready;
    assign s3_load  = !s3_valid_reg || out_load;
    assign s2_load  = !s2_valid_reg || !s2_result || s3_load;
    assign s1_load  = !s1_valid_reg || s2_load;
    assign in_ready = s1_load;
    assign in_fire  = in_valid && in_ready;
    assign s2_fire  = s2_valid_reg && s2_load;

    // ---------------- stage 0: position tracking ----------------
    logic [CW-1:0] column_reg;
    logic          row_odd_reg;
    logic [CW-1:0] col_cur;
    logic          row_cur;
    logic [WW-1:0] col_plus;
    logic          col_wrap;

    assign col_cur  = start_of_frame ? '0 : column_reg;
    assign row_cur  = start_of_frame ? 1'b0 : row_odd_reg;
    assign col_plus = WW'(col_cur) + WW'(1);
    assign col_wrap = col_plus >= width_eff;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            column_reg  <= '0;
            row_odd_reg <= 1'b0;
        end
        else if (in_fire)
        begin
            column_reg  <= col_wrap ? '0 : col_plus[CW-1:0];
            row_odd_reg <= col_wrap ? !row_cur : row_cur;
        end
    end

    // ---------------- stage 1: luminance ----------------
    logic [PIX_W-1:0]  s1_r_reg, s1_g_reg, s1_b_reg;
    logic              s1_odd_col_reg, s1_in_range_reg, s1_row_odd_reg, s1_last_reg;
    logic [ADDR_W-1:0] s1_idx_reg;
    logic [LUMA_W-1:0] s1_luma;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (s1_load)
        begin
            s1_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s1_r_reg        <= red;
            s1_g_reg        <= green;
            s1_b_reg        <= blue;
            s1_odd_col_reg  <= col_cur[0];
            s1_in_range_reg <= WW'(col_cur) < width_even;
            s1_row_odd_reg  <= row_cur;
            s1_last_reg     <= col_plus == width_even;
            s1_idx_reg      <= col_cur[ADDR_W:1];
        end
    end

    assign s1_luma = LUMA_W'(s1_r_reg) * LUMA_WEIGHT_R
                   + LUMA_W'(s1_g_reg) * LUMA_WEIGHT_G
                   + LUMA_W'(s1_b_reg) * LUMA_WEIGHT_B;

    // ---------------- stage 2: filter, pair sum, line access ----------------
    logic [PIX_W-1:0]  s2_r_reg, s2_g_reg, s2_b_reg;
    logic [LUMA_W-1:0] s2_luma_reg;
    logic              s2_odd_col_reg, s2_in_range_reg, s2_row_odd_reg, s2_last_reg;
    logic [ADDR_W-1:0] s2_idx_reg;
    logic [PIX_W-1:0]  left_r_reg, left_g_reg, left_b_reg;
    logic              keep;
    logic [PIX_W-1:0]  f_r, f_g, f_b;
    logic [SUM_W-1:0]  pair_r, pair_g, pair_b;
    logic              pair_ok;
    logic              mem_we, mem_re;
    logic [LINE_DW-1:0] mem_rdata;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
        end
        else if (s2_load)
        begin
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_valid_reg && s2_load)
        begin
            s2_r_reg        <= s1_r_reg;
            s2_g_reg        <= s1_g_reg;
            s2_b_reg        <= s1_b_reg;
            s2_luma_reg     <= s1_luma;
            s2_odd_col_reg  <= s1_odd_col_reg;
            s2_in_range_reg <= s1_in_range_reg;
            s2_row_odd_reg  <= s1_row_odd_reg;
            s2_last_reg     <= s1_last_reg;
            s2_idx_reg      <= s1_idx_reg;
        end
    end

    assign keep = !bp_enable_reg || (s2_luma_reg > luma_thresh_reg);
    assign f_r  = keep ? s2_r_reg : '0;
    assign f_g  = keep ? s2_g_reg : '0;
    assign f_b  = keep ? s2_b_reg : '0;

    assign pair_r = SUM_W'(left_r_reg) + SUM_W'(f_r);
    assign pair_g = SUM_W'(left_g_reg) + SUM_W'(f_g);
    assign pair_b = SUM_W'(left_b_reg) + SUM_W'(f_b);

    assign pair_ok   = s2_odd_col_reg && s2_in_range_reg;
    assign s2_result = pair_ok && s2_row_odd_reg;
    assign mem_we    = s2_fire && pair_ok && !s2_row_odd_reg;
    assign mem_re    = s2_fire && s2_result;

    // Hold the filtered pixel of every even column for the pair that follows
    always_ff @(posedge clk)
    begin
        if (s2_fire && !s2_odd_col_reg)
        begin
            left_r_reg <= f_r;
            left_g_reg <= f_g;
            left_b_reg <= f_b;
        end
    end

    bpbd_line_store #(
        .DEPTH  (LINE_DEPTH),
        .ADDR_W (ADDR_W)
    ) u_line_store (
        .clk     (clk),
        .wr_en   (mem_we),
        .wr_addr (s2_idx_reg),
        .wr_data ({pair_b, pair_g, pair_r}),
        .rd_en   (mem_re),
        .rd_addr (s2_idx_reg),
        .rd_data (mem_rdata)
    );

    // ---------------- stage 3: add the even-row sums ----------------
    logic [SUM_W-1:0]  s3_r_reg, s3_g_reg, s3_b_reg;
    logic              s3_last_reg;
    logic [QUAD_W-1:0] quad_r, quad_g, quad_b;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s3_valid_reg <= 1'b0;
        end
        else if (s3_load)
        begin
            s3_valid_reg <= s2_fire && s2_result;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_re)
        begin
            s3_r_reg    <= pair_r;
            s3_g_reg    <= pair_g;
            s3_b_reg    <= pair_b;
            s3_last_reg <= s2_last_reg;
        end
    end

    assign quad_r = QUAD_W'(s3_r_reg) + QUAD_W'(mem_rdata[SUM_W-1:0]);
    assign quad_g = QUAD_W'(s3_g_reg) + QUAD_W'(mem_rdata[2*SUM_W-1:SUM_W]);
    assign quad_b = QUAD_W'(s3_b_reg) + QUAD_W'(mem_rdata[3*SUM_W-1:2*SUM_W]);

    // ---------------- output register ----------------
    logic [PIX_W-1:0] avg_r_reg, avg_g_reg, avg_b_reg;
    logic             row_end_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            out_valid_reg <= s3_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load && s3_valid_reg)
        begin
            avg_r_reg   <= quad_r[QUAD_W-1:2];
            avg_g_reg   <= quad_g[QUAD_W-1:2];
            avg_b_reg   <= quad_b[QUAD_W-1:2];
            row_end_reg <= s3_last_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign avg_red   = avg_r_reg;
    assign avg_green = avg_g_reg;
    assign avg_blue  = avg_b_reg;
    assign row_end   = row_end_reg;

    // ---------------- assertions ----------------
    a_line_single_access: assert property (@(posedge clk) disable iff (!rst_n)
        !(mem_we && mem_re))
        else $error("line store written and read in the same cycle");

    a_stalled_read_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (s3_valid_reg && out_valid_reg && !out_ready) |=> (s3_valid_reg && $stable(mem_rdata)))
        else $error("line store read data lost while the result stage stalls");

    a_result_from_stage3: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(s3_valid_reg))
        else $error("result presented without a completed block behind it");

endmodule

`default_nettype wire

// ----- tb/bloom_downsample_checker.sv -----
// Watches the pixel and result channels, predicts each 2x2 average and compares.
`timescale 1ns / 1ps

module bloom_downsample_checker
    import bpbd_pkg::*;
#(
    parameter int MAX_WIDTH = DEFAULT_MAX_WIDTH
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_DW-1:0]    cfg_data,
    input  logic                 in_valid,
    input  logic                 in_ready,
    input  logic                 start_of_frame,
    input  logic [PIX_W-1:0]     red,
    input  logic [PIX_W-1:0]     green,
    input  logic [PIX_W-1:0]     blue,
    input  logic                 out_valid,
    input  logic                 out_ready,
    input  logic [PIX_W-1:0]     avg_red,
    input  logic [PIX_W-1:0]     avg_green,
    input  logic [PIX_W-1:0]     avg_blue,
    input  logic                 row_end,
    output int                   fail_count,
    output int                   pending
);

    localparam int LINE_DEPTH  = MAX_WIDTH / 2;

    typedef struct packed {
        logic [SUM_W-1:0] b;
        logic [SUM_W-1:0] g;
        logic [SUM_W-1:0] r;
    } pair_sum_t;

    typedef struct packed {
        logic [PIX_W-1:0] r;
        logic [PIX_W-1:0] g;
        logic [PIX_W-1:0] b;
        logic             last;
    } box_avg_t;

    logic [LW_W-1:0]   line_width_q;
    logic              bp_enable_q;
    logic [LUMA_W-1:0] luma_thresh_q;

    int unsigned       col_pos;
    logic              row_odd;
    logic [PIX_W-1:0]  hold_r, hold_g, hold_b;
    pair_sum_t         pair_line [0:LINE_DEPTH-1];

    box_avg_t          pending_averages [$];
    int                mismatches = 0;

    assign fail_count = mismatches;

    task automatic report_mismatch(input string msg);
        $display("[%0t] MISMATCH: %s", $realtime, msg);
        mismatches++;
    endtask

    task automatic predict_box_average(input logic sof, input logic [PIX_W-1:0] r_in,
                                       input logic [PIX_W-1:0] g_in,
                                       input logic [PIX_W-1:0] b_in);
        int unsigned      eff_w;
        int unsigned      even_w;
        int unsigned      idx;
        int unsigned      luma;
        logic [PIX_W-1:0] kr, kg, kb;
        logic [SUM_W-1:0] sr, sg, sb;
        logic [QUAD_W-1:0] qr, qg, qb;
        pair_sum_t        upper;
        box_avg_t         px;

        eff_w = 32'(line_width_q);
        if (eff_w < 2) eff_w = 2;
        if (eff_w > MAX_WIDTH) eff_w = MAX_WIDTH;
        even_w = eff_w & ~32'd1;

        if (sof)
        begin
            col_pos = 0;
            row_odd = 1'b0;
        end

        luma = 32'(LUMA_WEIGHT_R) * 32'(r_in)
             + 32'(LUMA_WEIGHT_G) * 32'(g_in)
             + 32'(LUMA_WEIGHT_B) * 32'(b_in);
        if (bp_enable_q && luma <= luma_thresh_q)
        begin
            kr = '0;
            kg = '0;
            kb = '0;
        end
        else
        begin
            kr = r_in;
            kg = g_in;
            kb = b_in;
        end

        if (col_pos[0] == 1'b0)
        begin
            hold_r = kr;
            hold_g = kg;
            hold_b = kb;
        end
        else if (col_pos < even_w)
        begin
            idx = (col_pos >> 1) % LINE_DEPTH;
            sr = SUM_W'(hold_r) + SUM_W'(kr);
            sg = SUM_W'(hold_g) + SUM_W'(kg);
            sb = SUM_W'(hold_b) + SUM_W'(kb);
            if (!row_odd)
            begin
                pair_line[idx] = '{b: sb, g: sg, r: sr};
            end
            else
            begin
                upper = pair_line[idx];
                qr = QUAD_W'(sr) + QUAD_W'(upper.r);
                qg = QUAD_W'(sg) + QUAD_W'(upper.g);
                qb = QUAD_W'(sb) + QUAD_W'(upper.b);
                px.r = qr[QUAD_W-1:2];
                px.g = qg[QUAD_W-1:2];
                px.b = qb[QUAD_W-1:2];
                px.last = (col_pos + 1 == even_w);
                pending_averages.push_back(px);
            end
        end

        // wrap the row once the column reaches the width, even if it overshot
        col_pos++;
        if (col_pos >= eff_w)
        begin
            col_pos = 0;
            row_odd = ~row_odd;
        end
    endtask

    task automatic check_average();
        box_avg_t want;

        if (pending_averages.size() == 0)
        begin
            report_mismatch($sformatf("result with none expected: %0d %0d %0d row_end %0b",
                                      avg_red, avg_green, avg_blue, row_end));
        end
        else
        begin
            want = pending_averages.pop_front();
            if (avg_red !== want.r)
                report_mismatch($sformatf("avg_red got %0d, want %0d", avg_red, want.r));
            if (avg_green !== want.g)
                report_mismatch($sformatf("avg_green got %0d, want %0d", avg_green, want.g));
            if (avg_blue !== want.b)
                report_mismatch($sformatf("avg_blue got %0d, want %0d", avg_blue, want.b));
            if (row_end !== want.last)
                report_mismatch($sformatf("row_end got %0b, want %0b", row_end, want.last));
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            line_width_q  = LINE_WIDTH_RST;
            bp_enable_q   = BP_ENABLE_RST;
            luma_thresh_q = LUMA_THRESH_RST;
            col_pos       = 0;
            row_odd       = 1'b0;
            hold_r        = '0;
            hold_g        = '0;
            hold_b        = '0;
            pending_averages.delete();
            pending      <= 0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_LINE_WIDTH:     line_width_q  = cfg_data[LW_W-1:0];
                    REG_BP_ENABLE:      bp_enable_q   = cfg_data[0];
                    REG_LUMA_THRESHOLD: luma_thresh_q = cfg_data[LUMA_W-1:0];
                    default: ;
                endcase
            end
            if (in_valid && in_ready)
                predict_box_average(start_of_frame, red, green, blue);
            if (out_valid && out_ready)
                check_average();
            pending <= pending_averages.size();
        end
    end

endmodule

// ----- tb/bright_pass_box_downsample_tb.sv -----
// Stimulus, reset and verdict for the bright-pass box downsampler.
`timescale 1ns / 1ps

module bright_pass_box_downsample_tb
    import bpbd_pkg::*;
();

    localparam int MAX_W         = DEFAULT_MAX_WIDTH;
    localparam int RANDOM_ITEMS  = 1080;
    localparam int SETTLE_CYCLES = 8;
    localparam int LONG_HOLD     = 250;
    localparam int WIDE_PIXELS   = 64;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = REG_LINE_WIDTH;
    logic [CFG_DW-1:0]    cfg_data = '0;
    logic                 in_valid = 1'b0;
    logic                 in_ready;
    logic                 start_of_frame = 1'b0;
    logic [PIX_W-1:0]     red = '0;
    logic [PIX_W-1:0]     green = '0;
    logic [PIX_W-1:0]     blue = '0;
    logic                 out_valid;
    logic                 out_ready = 1'b0;
    logic [PIX_W-1:0]     avg_red, avg_green, avg_blue;
    logic                 row_end;

    int                   fail_count;
    int                   pending;
    int                   tx_idle_pct = 0;
    int                   rx_idle_pct = 0;
    logic                 hold_off_req = 1'b0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    bright_pass_box_downsample #(.MAX_WIDTH(MAX_W)) i_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .start_of_frame (start_of_frame),
        .red            (red),
        .green          (green),
        .blue           (blue),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .avg_red        (avg_red),
        .avg_green      (avg_green),
        .avg_blue       (avg_blue),
        .row_end        (row_end)
    );

    bloom_downsample_checker #(.MAX_WIDTH(MAX_W)) i_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .start_of_frame (start_of_frame),
        .red            (red),
        .green          (green),
        .blue           (blue),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .avg_red        (avg_red),
        .avg_green      (avg_green),
        .avg_blue       (avg_blue),
        .row_end        (row_end),
        .fail_count     (fail_count),
        .pending        (pending)
    );

    // mostly no gap, some short ones, the odd long one
    function automatic int pick_gap(input int pct);
        if ($urandom_range(0, 99) >= pct)
            return 0;
        if ($urandom_range(0, 7) == 0)
            return $urandom_range(8, 40);
        return $urandom_range(1, 3);
    endfunction

    function automatic int pick_pct();
        case ($urandom_range(0, 3))
            0:       return 0;
            1:       return 10;
            2:       return 30;
            default: return 60;
        endcase
    endfunction

    function automatic logic [PIX_W-1:0] pick_channel();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return '1;
            default: return PIX_W'($urandom_range(0, 255));
        endcase
    endfunction

    function automatic logic [LW_W-1:0] pick_width();
        int k;
        k = $urandom_range(0, 19);
        if (k == 0)
            return LW_W'($urandom_range(0, 1));
        if (k == 1)
            return LW_W'($urandom_range(100, 300));
        if (k < 8)
            return LW_W'(2 * $urandom_range(1, 8) + 1);
        return LW_W'($urandom_range(2, 16));
    endfunction

    function automatic logic [LUMA_W-1:0] pick_threshold();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return LUMA_W'(2550000);
            2:       return '1;
            3:       return LUMA_THRESH_RST;
            default: return LUMA_W'($urandom_range(0, 2550000));
        endcase
    endfunction

    function automatic int clamp_width(input logic [LW_W-1:0] w);
        if (w < 2)
            return 2;
        if (w > MAX_W)
            return MAX_W;
        return int'(w);
    endfunction

    task automatic set_registers(input logic [LW_W-1:0] w, input logic enable,
                                 input logic [LUMA_W-1:0] thresh);
        cfg_we    <= 1'b1;
        cfg_index <= REG_LINE_WIDTH;
        cfg_data  <= CFG_DW'(w);
        @(posedge clk);
        cfg_index <= REG_BP_ENABLE;
        cfg_data  <= CFG_DW'(enable);
        @(posedge clk);
        cfg_index <= REG_LUMA_THRESHOLD;
        cfg_data  <= CFG_DW'(thresh);
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    task automatic send_pixel(input logic sof, input logic [PIX_W-1:0] r,
                              input logic [PIX_W-1:0] g, input logic [PIX_W-1:0] b);
        int gap;
        in_valid       <= 1'b1;
        start_of_frame <= sof;
        red            <= r;
        green          <= g;
        blue           <= b;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        gap = pick_gap(tx_idle_pct);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // one frame; a stray start flag now and then restarts it, a cut ends it early
    task automatic send_frame(input int cols, input int rows, input logic may_cut,
                              output int sent);
        int total;
        int stop_at;
        total   = cols * rows;
        stop_at = total;
        if (may_cut && $urandom_range(0, 3) == 0)
            stop_at = $urandom_range(1, total);
        for (int i = 0; i < stop_at; i++)
            send_pixel(i == 0 || $urandom_range(0, 49) == 0,
                       pick_channel(), pick_channel(), pick_channel());
        sent = stop_at;
    endtask

    // drop valid, let every expected result out, then let the pipeline drain
    task automatic settle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    initial
    begin : result_sink
        int stall;
        forever
        begin
            @(posedge clk);
            if (hold_off_req)
            begin
                hold_off_req = 1'b0;
                out_ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
            end
            else
            begin
                stall = pick_gap(rx_idle_pct);
                out_ready <= (stall == 0);
                if (stall > 1)
                    repeat (stall - 1) @(posedge clk);
            end
        end
    end

    initial
    begin
        #40_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

    initial
    begin : stimulus
        int               sent;
        int               random_sent;
        int               cols;
        int               rows;
        logic [LW_W-1:0]  width_reg;

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // width below range clamps to two; a pixel exactly at threshold is dropped
        tx_idle_pct = 30;
        rx_idle_pct = 30;
        set_registers(LW_W'(0), 1'b1, LUMA_W'(10000));
        send_pixel(1'b1, 8'd1, 8'd1, 8'd1);
        send_pixel(1'b0, 8'd2, 8'd1, 8'd1);
        send_pixel(1'b0, 8'd255, 8'd255, 8'd255);
        send_pixel(1'b0, 8'd0, 8'd0, 8'd0);
        settle();

        // bright-pass off, full-scale pixels
        set_registers(LW_W'(1), 1'b0, LUMA_THRESH_RST);
        send_pixel(1'b1, 8'd255, 8'd255, 8'd255);
        send_pixel(1'b0, 8'd255, 8'd255, 8'd255);
        send_pixel(1'b0, 8'd255, 8'd255, 8'd255);
        send_pixel(1'b0, 8'd255, 8'd255, 8'd255);
        settle();

        // odd width: the last column of each row is dropped; zero threshold keeps non-black
        set_registers(LW_W'(5), 1'b1, '0);
        send_pixel(1'b1, 8'd0, 8'd0, 8'd0);
        send_pixel(1'b0, 8'd0, 8'd0, 8'd1);
        send_pixel(1'b0, 8'd255, 8'd0, 8'd0);
        send_pixel(1'b0, 8'd0, 8'd255, 8'd0);
        send_pixel(1'b0, 8'd0, 8'd0, 8'd255);
        send_pixel(1'b0, 8'd255, 8'd255, 8'd255);
        send_pixel(1'b0, 8'd128, 8'd64, 8'd32);
        send_pixel(1'b0, 8'd1, 8'd2, 8'd3);
        send_pixel(1'b0, 8'd0, 8'd0, 8'd0);
        send_pixel(1'b0, 8'd200, 8'd100, 8'd50);
        settle();

        // lower the width mid-row: the overshooting column makes nothing and wraps
        set_registers(LW_W'(6), 1'b1, '1);
        send_pixel(1'b1, 8'd255, 8'd255, 8'd255);
        send_pixel(1'b0, 8'd255, 8'd255, 8'd255);
        send_pixel(1'b0, 8'd10, 8'd20, 8'd30);
        settle();
        set_registers(LW_W'(2), 1'b0, '1);
        send_pixel(1'b0, 8'd77, 8'd88, 8'd99);
        send_pixel(1'b0, 8'd255, 8'd255, 8'd255);
        send_pixel(1'b0, 8'd255, 8'd255, 8'd255);
        settle();

        // hold the receiver off while the sender keeps pushing, so the input stalls
        set_registers(LW_W'(8), 1'b1, '0);
        tx_idle_pct  = 0;
        rx_idle_pct  = 0;
        hold_off_req = 1'b1;
        send_frame(8, 24, 1'b0, sent);
        settle();

        // width above range clamps to the widest row: a short even row gives no result
        set_registers('1, 1'b0, LUMA_THRESH_RST);
        tx_idle_pct = 5;
        rx_idle_pct = 5;
        send_frame(WIDE_PIXELS, 1, 1'b0, sent);

        random_sent = 0;
        while (random_sent < RANDOM_ITEMS)
        begin
            settle();
            width_reg = pick_width();
            set_registers(width_reg, $urandom_range(0, 3) != 0, pick_threshold());
            tx_idle_pct = pick_pct();
            rx_idle_pct = pick_pct();
            cols = clamp_width(width_reg);
            rows = (cols > 16) ? 2 : $urandom_range(2, 6);
            send_frame(cols, rows, 1'b1, sent);
            random_sent += sent;
        end

        settle();
        if (fail_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
